@@ rtl/fvbd_pkg.sv @@
// Shared types and constants for the video frame backlog with drop policy.
package fvbd_pkg;

    // One queued frame: key flag above the 32-bit timestamp
    typedef struct packed {
        logic        key;
        logic [31:0] pts;
    } slot_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic  shift_all;
        logic  shift_nk;
        logic  enq;
        slot_t inc;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        EV_QUEUED   = 3'd0,
        EV_BLOCKED  = 3'd1,
        EV_IN_DROP  = 3'd2,
        EV_EXPIRED  = 3'd3,
        EV_NK_DROP  = 3'd4,
        EV_OLD_DROP = 3'd5,
        EV_RENDERED = 3'd6,
        EV_EMPTY    = 3'd7
    } event_kind_t;

    localparam logic [1:0]  POLICY_NEVER = 2'd0;
    localparam logic        REG_POLICY   = 1'b0;
    localparam logic        REG_TOL      = 1'b1;
    localparam logic [15:0] TOL_RESET    = 16'd80;
    localparam logic        REQ_RENDER   = 1'b1;

endpackage

@@ rtl/fvbd_cell.sv @@
// One queue slot of the frame chain: holds a frame, shifts toward the head.
module fvbd_cell #(
    parameter int DEPTH = 8,
    parameter int IDX   = 0,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic [CW-1:0]       count,
    input  fvbd_pkg::cell_ctrl_t ctrl,
    input  fvbd_pkg::slot_t     right_slot,
    input  logic                seen_in,
    output fvbd_pkg::slot_t     slot,
    output logic                seen_out,
    output logic [31:0]         first_pts
);
    import fvbd_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  occupied;
    logic  nonkey;
    logic  shift;
    logic  load;

    // Flag occupancy and the first queued non-key frame along the chain
    assign occupied  = count > CW'(IDX);
    assign nonkey    = occupied & ~slot_reg.key;
    assign seen_out  = seen_in | nonkey;
    assign first_pts = (nonkey & ~seen_in) ? slot_reg.pts : 32'd0;

    // Take the neighbor's frame on a removal at or before this slot
    assign shift = ctrl.shift_all | (ctrl.shift_nk & seen_out);
    assign load  = ctrl.enq & (count == CW'(IDX));

    always_comb
    begin
        priority if (shift)
        begin
            slot_next = right_slot;
        end
        else if (load)
        begin
            slot_next = ctrl.inc;
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

@@ rtl/fvbd_ctrl.sv @@
// Request sequencer: walks the drop policy, drives the cells, registers events.
module fvbd_ctrl #(
    parameter int DEPTH = 8,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,
    input  logic [71:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2:0]           m_tuser,
    output logic [39:0]          m_tdata,
    output logic                 m_tlast,
    input  logic [1:0]           drop_policy,
    input  logic [15:0]          tolerance_ms,
    input  fvbd_pkg::slot_t      head,
    input  logic                 nonkey_any,
    input  logic [31:0]          first_nk_pts,
    output logic [CW-1:0]        count,
    output fvbd_pkg::cell_ctrl_t cell_ctrl
);
    import fvbd_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PURGE  = 6'b000010,
        ST_PUSH   = 6'b000100,
        ST_ENQ    = 6'b001000,
        ST_RENDER = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic        req_reg;
    slot_t       inc_reg;
    logic [31:0] now_reg;

    logic        out_valid_reg, out_valid_next;
    event_kind_t out_kind_reg;
    slot_t       out_slot_reg;
    logic [5:0]  out_cnt_reg;
    logic        out_last_reg;

    logic        emit_ok;
    logic        emit;
    event_kind_t ev_kind;
    slot_t       ev_slot;
    logic        ev_last;
    logic        catchup;
    logic        head_exp;
    logic        inc_exp;
    logic        full;

    function automatic logic expired(slot_t s, logic [31:0] now, logic [15:0] tol);
        logic [32:0] sum;
        sum = {1'b0, s.pts} + {17'd0, tol};
        return sum < {1'b0, now};
    endfunction

    assign catchup  = drop_policy[1];
    assign emit_ok  = ~out_valid_reg | m_tready;
    assign head_exp = (count_reg != '0) & ~head.key & expired(head, now_reg, tolerance_ms);
    assign inc_exp  = ~inc_reg.key & expired(inc_reg, now_reg, tolerance_ms);
    assign full     = count_reg >= CW'(DEPTH);
    assign s_tready = state_reg == ST_IDLE;

    // Sequence one request, registering each event while the output is free
    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        emit                = 1'b0;
        ev_kind             = EV_QUEUED;
        ev_slot             = inc_reg;
        ev_last             = 1'b0;
        cell_ctrl.shift_all = 1'b0;
        cell_ctrl.shift_nk  = 1'b0;
        cell_ctrl.enq       = 1'b0;
        cell_ctrl.inc       = inc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (catchup)
                        state_next = ST_PURGE;
                    else if (s_tuser == REQ_RENDER)
                        state_next = ST_RENDER;
                    else
                        state_next = ST_PUSH;
                end
            end
            ST_PURGE:
            begin
                if (emit_ok)
                begin
                    priority if (head_exp)
                    begin
                        emit                = 1'b1;
                        ev_kind             = EV_EXPIRED;
                        ev_slot             = head;
                        cell_ctrl.shift_all = 1'b1;
                        count_next          = count_reg - 1'b1;
                    end
                    else if (req_reg == REQ_RENDER)
                    begin
                        state_next = ST_RENDER;
                    end
                    else if (inc_exp)
                    begin
                        emit       = 1'b1;
                        ev_kind    = EV_IN_DROP;
                        ev_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    priority if (!full)
                    begin
                        cell_ctrl.enq = 1'b1;
                        count_next    = count_reg + 1'b1;
                        ev_last       = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else if (drop_policy == POLICY_NEVER)
                    begin
                        ev_kind    = EV_BLOCKED;
                        ev_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (nonkey_any)
                    begin
                        ev_kind            = EV_NK_DROP;
                        ev_slot            = '{key: 1'b0, pts: first_nk_pts};
                        cell_ctrl.shift_nk = 1'b1;
                        count_next         = count_reg - 1'b1;
                        state_next         = ST_ENQ;
                    end
                    else if (catchup)
                    begin
                        ev_kind    = EV_BLOCKED;
                        ev_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (!inc_reg.key)
                    begin
                        ev_kind    = EV_IN_DROP;
                        ev_last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ev_kind             = EV_OLD_DROP;
                        ev_slot             = head;
                        cell_ctrl.shift_all = 1'b1;
                        count_next          = count_reg - 1'b1;
                        state_next          = ST_ENQ;
                    end
                end
            end
            ST_ENQ:
            begin
                if (emit_ok)
                begin
                    emit          = 1'b1;
                    cell_ctrl.enq = 1'b1;
                    count_next    = count_reg + 1'b1;
                    ev_last       = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RENDER:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    ev_last    = 1'b1;
                    state_next = ST_IDLE;
                    if (count_reg == '0)
                    begin
                        ev_kind = EV_EMPTY;
                        ev_slot = '0;
                    end
                    else
                    begin
                        ev_kind             = EV_RENDERED;
                        ev_slot             = head;
                        cell_ctrl.shift_all = 1'b1;
                        count_next          = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output transaction until it is taken
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and the event payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg     <= s_tuser;
            inc_reg.pts <= s_tdata[31:0];
            inc_reg.key <= s_tdata[32];
            now_reg     <= s_tdata[64:33];
        end
        if (emit)
        begin
            out_kind_reg <= ev_kind;
            out_slot_reg <= ev_slot;
            out_cnt_reg  <= 6'(count_next);
            out_last_reg <= ev_last;
        end
    end

    assign count    = count_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {1'b0, out_cnt_reg, out_slot_reg.key, out_slot_reg.pts};
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("backlog count beyond queue depth");

    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ENQ |-> count_reg < CW'(DEPTH))
        else $error("enqueue after a drop found no free slot");

    a_expired_nonkey: assert property (@(posedge clk) disable iff (!rst_n)
        emit && ev_kind == EV_EXPIRED |-> !head.key && count_reg != '0)
        else $error("expired drop of a key frame or from an empty queue");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && ev_last |=> state_reg == ST_IDLE)
        else $error("request continued after its final event");

endmodule

@@ rtl/video_frame_backlog_drop_policy_top.sv @@
// The first event is registered from ST_PUSH or ST_RENDER, under catch-up policy from
// ST_PURGE or the state it then picks. Events leave through the output register, one per
// cycle while the output is free, plus an eventless decision step under catch-up policy.
// The next request is taken once the final event of the current one is registered.
// Reset: backlog count 0, drop_policy 0, tolerance_ms 80; slot contents not cleared.
module video_frame_backlog_drop_policy_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // req_type
    input  logic [71:0] s_tdata,   // pts_ms[31:0], key_frame[32], now_ms[64:33], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // event_kind
    output logic [39:0] m_tdata,   // frame_pts[31:0], frame_is_key[32], backlog_count[38:33]
    output logic        m_tlast    // last_event
);
    import fvbd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]  policy_reg;
    logic [15:0] tol_reg;
    logic        cfg_wr;

    logic [CW-1:0] count;
    cell_ctrl_t    cell_ctrl;
    slot_t         slots [QUEUE_DEPTH];
    slot_t         right [QUEUE_DEPTH];
    logic          seen  [QUEUE_DEPTH+1];
    logic [31:0]   fpts  [QUEUE_DEPTH];
    logic [31:0]   first_nk_pts;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_NEVER;
            tol_reg    <= TOL_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_POLICY)
                policy_reg <= pwdata[1:0];
            else
                tol_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOL) ? {16'd0, tol_reg} : {30'd0, policy_reg};

    // Chain of frame cells, head at index zero
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right[i] = '0;
        end
        else
        begin : g_mid
            assign right[i] = slots[i+1];
        end

        fvbd_cell #(
            .DEPTH (QUEUE_DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .count      (count),
            .ctrl       (cell_ctrl),
            .right_slot (right[i]),
            .seen_in    (seen[i]),
            .slot       (slots[i]),
            .seen_out   (seen[i+1]),
            .first_pts  (fpts[i])
        );
    end

    // Gather the timestamp of the first queued non-key frame
    always_comb
    begin
        first_nk_pts = 32'd0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            first_nk_pts = first_nk_pts | fpts[i];
    end

    fvbd_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .drop_policy  (policy_reg),
        .tolerance_ms (tol_reg),
        .head         (slots[0]),
        .nonkey_any   (seen[QUEUE_DEPTH]),
        .first_nk_pts (first_nk_pts),
        .count        (count),
        .cell_ctrl    (cell_ctrl)
    );

endmodule

@@ dv/tb_video_frame_backlog_drop_policy_top.sv @@
// Self-checking testbench for the video frame backlog with selectable drop policy.
`timescale 1ns / 100ps

module tb_video_frame_backlog_drop_policy_top;
    import fvbd_pkg::*;

    localparam int DEPTH = 8;

    localparam logic [1:0] POLICY_NONKEY   = 2'd1;
    localparam logic [1:0] POLICY_CATCHUP  = 2'd2;
    localparam logic [1:0] POLICY_CATCHUP3 = 2'd3;
    localparam logic       REQ_PUSH        = ~REQ_RENDER;
    localparam logic [2:0] ADDR_POLICY     = {REG_POLICY, 2'b00};
    localparam logic [2:0] ADDR_TOL        = {REG_TOL, 2'b00};

    // One event as the block should report it
    typedef struct {
        event_kind_t kind;
        logic [31:0] pts;
        logic        key;
        logic [5:0]  count;
        logic        last;
    } backlog_event_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tuser;   // req_type
    logic [71:0] s_tdata;   // pts_ms[31:0], key_frame[32], now_ms[64:33], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [2:0]  m_tuser;   // event_kind
    logic [39:0] m_tdata;   // frame_pts[31:0], frame_is_key[32], backlog_count[38:33]
    logic        m_tlast;   // last_event

    // Shadow copy of the block state and its registers
    slot_t          shadow_backlog[$];
    logic [1:0]     cur_policy;
    logic [15:0]    cur_tol;
    backlog_event_t pending_events[$];

    int          tx_idle_pct;
    int          rx_stall_pct;
    int          hold_left;
    int          mismatches;
    int          items_sent;
    int          events_checked;
    int          kind_seen[8];
    logic [31:0] media_ms;

    video_frame_backlog_drop_policy_top #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #2_000_000;
        $display("[video_frame_backlog_drop_policy_top] ERROR");
        $display("Timeout with %0d events still awaited", pending_events.size());
        $finish;
    end

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    // ---------------------------------------------------------------
    // Backlog predictor
    // ---------------------------------------------------------------

    // Compare at 33 bits so pts + tolerance never wraps
    function automatic bit is_stale(input slot_t frame, input logic [31:0] now);
        return ({1'b0, frame.pts} + {17'd0, cur_tol}) < {1'b0, now};
    endfunction

    // Remove and return the oldest shadow frame
    function automatic slot_t take_oldest();
        slot_t frame;
        frame = shadow_backlog[0];
        shadow_backlog.delete(0);
        return frame;
    endfunction

    function automatic void note_event(input event_kind_t kind, input slot_t frame);
        pending_events.insert(pending_events.size(),
                              '{kind, frame.pts, frame.key,
                                6'(shadow_backlog.size()), 1'b0});
    endfunction

    function automatic void admit(input slot_t frame);
        shadow_backlog.insert(shadow_backlog.size(), frame);
        note_event(EV_QUEUED, frame);
    endfunction

    // Drop expired non-key frames from the head
    function automatic void purge_stale(input logic [31:0] now);
        while (shadow_backlog.size() > 0 && !shadow_backlog[0].key &&
               is_stale(shadow_backlog[0], now))
            note_event(EV_EXPIRED, take_oldest());
    endfunction

    function automatic void predict_events(input logic rq, input logic [31:0] pts,
                                           input logic key, input logic [31:0] now);
        slot_t inc;
        slot_t victim;
        bit    catchup;
        int    nk_idx;
        inc     = {key, pts};
        catchup = (cur_policy >= POLICY_CATCHUP);
        if (rq == REQ_RENDER)
        begin
            if (catchup)
                purge_stale(now);
            if (shadow_backlog.size() == 0)
                note_event(EV_EMPTY, '0);
            else
                note_event(EV_RENDERED, take_oldest());
        end
        else
        begin
            if (catchup)
                purge_stale(now);
            if (catchup && !inc.key && is_stale(inc, now))
                note_event(EV_IN_DROP, inc);
            else if (shadow_backlog.size() < DEPTH)
                admit(inc);
            else if (cur_policy == POLICY_NEVER)
                note_event(EV_BLOCKED, inc);
            else
            begin
                nk_idx = -1;
                foreach (shadow_backlog[i])
                    if (nk_idx < 0 && !shadow_backlog[i].key)
                        nk_idx = i;
                if (nk_idx >= 0)
                begin
                    victim = shadow_backlog[nk_idx];
                    shadow_backlog.delete(nk_idx);
                    note_event(EV_NK_DROP, victim);
                    admit(inc);
                end
                else if (catchup)
                    note_event(EV_BLOCKED, inc);
                else if (!inc.key)
                    note_event(EV_IN_DROP, inc);
                else
                begin
                    note_event(EV_OLD_DROP, take_oldest());
                    admit(inc);
                end
            end
        end
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------

    // Drive ready; a requested hold-off is counted down here
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Check each event transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        backlog_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_checked++;
            kind_seen[m_tuser]++;
            if (pending_events.size() == 0)
                flag_mismatch($sformatf("unexpected event kind %0d pts %h",
                                        m_tuser, m_tdata[31:0]));
            else
            begin
                want = pending_events[0];
                pending_events.delete(0);
                if (m_tuser !== want.kind || m_tdata[31:0] !== want.pts ||
                    m_tdata[32] !== want.key || m_tdata[38:33] !== want.count ||
                    m_tlast !== want.last)
                    flag_mismatch($sformatf(
                        "expected kind %0d pts %h key %0b count %0d last %0b, %s",
                        want.kind, want.pts, want.key, want.count, want.last,
                        $sformatf("got kind %0d pts %h key %0b count %0d last %0b",
                                  m_tuser, m_tdata[31:0], m_tdata[32],
                                  m_tdata[38:33], m_tlast)));
            end
        end
    end

    // ---------------------------------------------------------------
    // Request side and register access
    // ---------------------------------------------------------------

    task automatic send_request(input logic rq, input logic [31:0] pts,
                                input logic key, input logic [31:0] now);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < tx_idle_pct)
            gap = $urandom_range(1, 12);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = rq;
        s_tdata  = {7'd0, now, key, pts};
        do
            @(posedge clk);
        while (!s_tready);
        predict_events(rq, pts, key, now);
        items_sent++;
    endtask

    // Stop offering and wait until every expected event has arrived
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then read it back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== value)
            flag_mismatch($sformatf("register %0d read %h, expected %h",
                                    addr, prdata, value));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(input logic [1:0] policy, input logic [15:0] tol);
        wait_drained();
        write_reg(ADDR_POLICY, {30'd0, policy});
        write_reg(ADDR_TOL, {16'd0, tol});
        cur_policy = policy;
        cur_tol    = tol;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // Timestamps track a running media clock so expiry cuts both ways
    task automatic random_traffic(input int count);
        logic        rq;
        logic        key;
        logic [31:0] pts;
        logic [31:0] now;
        int          span;
        span = int'(cur_tol);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                rq  = 1'($urandom_range(0, 1));
                key = 1'($urandom_range(0, 1));
                pts = $urandom;
                now = $urandom;
            end
            else
            begin
                media_ms += $urandom_range(0, span / 4 + 8);
                now = media_ms;
                rq  = ($urandom_range(0, 99) < 42);
                key = ($urandom_range(0, 3) == 0);
                pts = now - $urandom_range(0, 2 * span + 40) + 20;
            end
            send_request(rq, pts, key, now);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fill under never-drop, then push into the full queue
    task automatic test_never_drop();
        configure(POLICY_NEVER, TOL_RESET);
        send_request(REQ_RENDER, $urandom, 1'($urandom_range(0, 1)), 32'd0);
        send_request(REQ_PUSH, 32'h0000_0000, 1'b0, 32'd0);
        send_request(REQ_PUSH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 32'd100, 1'b1, 32'd0);
        send_request(REQ_PUSH, 32'd101, 1'b0, 32'd0);
        for (int i = 102; i < 106; i++)
            send_request(REQ_PUSH, i, 1'b1, 32'd0);
        send_request(REQ_PUSH, 32'd7, 1'b0, 32'd0);
    endtask

    // Full queue: drop queued non-key, drop incoming, evict oldest
    task automatic test_drop_non_key();
        configure(POLICY_NONKEY, TOL_RESET);
        send_request(REQ_PUSH, 32'd200, 1'b0, 32'd0);
        send_request(REQ_PUSH, 32'd300, 1'b1, 32'd0);
        send_request(REQ_PUSH, 32'd301, 1'b1, 32'd0);
        send_request(REQ_PUSH, 32'd400, 1'b0, 32'd0);
        send_request(REQ_PUSH, 32'd500, 1'b1, 32'd0);
    endtask

    // Catch-up: expired incoming, blocked, wide-sum timestamp, policy code three
    task automatic test_catch_up();
        configure(POLICY_CATCHUP, 16'hFFFF);
        send_request(REQ_PUSH, 32'd0, 1'b0, 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 32'd0, 1'b1, 32'hFFFF_FFFF);
        send_request(REQ_RENDER, $urandom, 1'($urandom_range(0, 1)), 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        send_request(REQ_PUSH, 32'd5, 1'b1, 32'd0);
        configure(POLICY_CATCHUP3, 16'd0);
        send_request(REQ_RENDER, $urandom, 1'($urandom_range(0, 1)), 32'd0);
    endtask

    task automatic test_random_policy(input logic [1:0] policy, input logic [15:0] tol,
                                      input int count);
        configure(policy, tol);
        random_traffic(count);
    endtask

    // Hold the result side off so the block backs up, then pause the sender
    task automatic test_backlog_pressure();
        configure(POLICY_NONKEY, 16'd40);
        hold_left = 250;
        random_traffic(20);
        wait_drained();
        random_traffic(10);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tuser        = 1'b0;
        s_tdata        = '0;
        hold_left      = 0;
        mismatches     = 0;
        items_sent     = 0;
        events_checked = 0;
        cur_policy     = POLICY_NEVER;
        cur_tol        = TOL_RESET;
        media_ms       = $urandom;
        set_idling(31, 87);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_never_drop();
        test_drop_non_key();
        test_catch_up();

        test_random_policy(POLICY_NONKEY, TOL_RESET, 65);
        test_random_policy(POLICY_CATCHUP, TOL_RESET, 65);
        set_idling(87, 31);
        test_random_policy(POLICY_NEVER, 16'hFFFF, 60);
        test_random_policy(POLICY_CATCHUP3, 16'd0, 60);
        set_idling(0, 0);
        test_backlog_pressure();
        test_random_policy(POLICY_CATCHUP, 16'd500, 65);

        // Let the tail drain, then watch for stray events
        @(negedge clk);
        s_tvalid = 1'b0;
        for (int guard = 0; guard < 20000 && pending_events.size() != 0; guard++)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (pending_events.size() != 0)
            flag_mismatch($sformatf("%0d events never arrived", pending_events.size()));

        $display("Covered %0d requests, %0d events, policy codes 0-3, tolerance 0-65535",
                 items_sent, events_checked);
        $display("Events by kind queued..empty: %0d %0d %0d %0d %0d %0d %0d %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
        if (mismatches == 0)
            $display("[video_frame_backlog_drop_policy_top] OK");
        else
            $display("[video_frame_backlog_drop_policy_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fvbd_pkg.sv
rtl/fvbd_cell.sv
rtl/fvbd_ctrl.sv
rtl/video_frame_backlog_drop_policy_top.sv
dv/tb_video_frame_backlog_drop_policy_top.sv
